// File: sv/fsp_pkg.sv
// Shared types and constants for the fixed-size object pool.
package fsp_pkg;

   localparam int ADDR_W     = 48;
   localparam int ELEM_W     = 12;
   localparam int CHUNK_W    = 13;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STACK_FULL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNKS_PER_PAGE = 2'd1;

   localparam logic [ELEM_W-1:0] RESET_ELEMENT_SIZE = 12'd16;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] free_address;
      logic [ADDR_W-1:0] fresh_page_base;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   chunk_address;
      logic [STATUS_W-1:0] status;
      logic                page_taken;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

endpackage

// File: sv/fsp_if.sv
// Handshake channel interfaces for requests, responses and register writes.
interface fsp_req_if;
   import fsp_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fsp_rsp_if;
   import fsp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fsp_csr_if;
   import fsp_pkg::*;
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: sv/fsp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fsp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/fixed_size_object_pool.sv
// Fixed-size object pool allocator: recycled chunks come from a last-in first-out
// stack held in a RAM; otherwise chunks are carved from the current page, and a
// fresh page base from the request is taken when the page is used up. In the
// accept cycle of a request the state is updated and the stack RAM is
// written (free) or read (allocate from the stack); then, once no earlier response
// is still waiting to be taken, the RAM read data, the status, the fresh page base
// or the base plus index times element size is loaded into the response register.
// A new request can be accepted as soon as that register has been loaded, even
// while the response still waits to be taken, but not before. No clearing pass
// is needed after reset.
module fixed_size_object_pool #(
   parameter int MAX_PAGES   = 16,
   parameter int STACK_DEPTH = 64,
   parameter int PAGE_BYTES  = 4096,
   parameter int ADDR_BITS   = 48
) (
   input  logic    clock,
   input  logic    reset,
   fsp_req_if.sink   req_bus,
   fsp_rsp_if.source rsp_bus,
   fsp_csr_if.sink   csr_bus
);
   import fsp_pkg::*;

   localparam int PG_W  = $clog2(MAX_PAGES + 1);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int PROD_W = CHUNK_W + ELEM_W;

   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1));
   localparam logic [CHUNK_W-1:0] RESET_CHUNKS = CHUNK_W'(PAGE_BYTES / 16);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   localparam logic [2:0] KIND_PUSH      = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_POP       = 3'd2;
   localparam logic [2:0] KIND_NEW_PAGE  = 3'd3;
   localparam logic [2:0] KIND_NO_PAGE   = 3'd4;
   localparam logic [2:0] KIND_BUMP      = 3'd5;

   logic                state_ff;
   logic [2:0]          kind_ff;
   logic [2:0]          kind;
   logic [ELEM_W-1:0]   elem_size_ff;
   logic [CHUNK_W-1:0]  chunks_ff;
   logic [CHUNK_W-1:0]  chunk_idx_ff;
   logic [PG_W-1:0]     pages_ff;
   logic [ADDR_W-1:0]   page_base_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_less;
   logic [CHUNK_W:0]    next_idx;
   logic                accept;
   logic                rsp_load;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic [PROD_W-1:0]   product;
   logic [ADDR_W-1:0]   bump_addr;
   logic [ADDR_W-1:0]   stack_rd_data;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   assign next_idx   = {1'b0, chunk_idx_ff} + (CHUNK_W + 1)'(1);
   assign count_less = count_ff - CNT_W'(1);

   always_comb begin
      kind = KIND_BUMP;
      priority if (req_bus.payload.cmd == CMD_FREE) begin
         kind = (count_ff >= CNT_W'(STACK_DEPTH)) ? KIND_FULL : KIND_PUSH;
      end else if (count_ff != '0) begin
         kind = KIND_POP;
      end else if (next_idx >= {1'b0, chunks_ff}) begin
         kind = (pages_ff >= PG_W'(MAX_PAGES)) ? KIND_NO_PAGE : KIND_NEW_PAGE;
      end else begin
         kind = KIND_BUMP;
      end
   end

   fsp_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (accept && (kind == KIND_PUSH)),
      .wr_addr (count_ff[SA_W-1:0]),
      .wr_data (req_bus.payload.free_address & ADDR_MASK),
      .rd_en   (accept && (kind == KIND_POP)),
      .rd_addr (count_less[SA_W-1:0]),
      .rd_data (stack_rd_data)
   );

   assign product   = PROD_W'(chunk_idx_ff) * PROD_W'(elem_size_ff);
   assign bump_addr = (page_base_ff + ADDR_W'(product)) & ADDR_MASK;
   assign rsp_load  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      rsp_in = '0;
      unique case (kind_ff)
         KIND_PUSH:     rsp_in.status = STATUS_OK;
         KIND_FULL:     rsp_in.status = STATUS_STACK_FULL;
         KIND_POP:      rsp_in.chunk_address = stack_rd_data;
         KIND_NEW_PAGE: begin
            rsp_in.chunk_address = page_base_ff;
            rsp_in.page_taken    = 1'b1;
         end
         KIND_NO_PAGE:  rsp_in.status = STATUS_NO_PAGE;
         KIND_BUMP:     rsp_in.chunk_address = bump_addr;
         default:       rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         elem_size_ff <= RESET_ELEMENT_SIZE;
         chunks_ff    <= RESET_CHUNKS;
         chunk_idx_ff <= RESET_CHUNKS - CHUNK_W'(1);
         pages_ff     <= '0;
         page_base_ff <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_bus.valid) begin
            unique case (csr_bus.payload.reg_index)
               CSR_ELEMENT_SIZE:    elem_size_ff <= csr_bus.payload.data[ELEM_W-1:0];
               CSR_CHUNKS_PER_PAGE: chunks_ff <= csr_bus.payload.data[CHUNK_W-1:0];
               default:             ;
            endcase
         end
         if (accept) begin
            state_ff <= ST_EXEC;
            kind_ff  <= kind;
            unique case (kind)
               KIND_PUSH: count_ff <= count_ff + CNT_W'(1);
               KIND_POP:  count_ff <= count_less;
               KIND_NEW_PAGE: begin
                  chunk_idx_ff <= '0;
                  pages_ff     <= pages_ff + PG_W'(1);
                  page_base_ff <= req_bus.payload.fresh_page_base & ADDR_MASK;
               end
               KIND_BUMP: chunk_idx_ff <= next_idx[CHUNK_W-1:0];
               default:   ;
            endcase
         end
         if (rsp_load) begin
            state_ff     <= ST_IDLE;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
